// File: sv/coh_pkg.sv
`timescale 1ns / 1ps

package coh_pkg;

    localparam logic [1:0] KIND_DELIVER  = 2'd0;
    localparam logic [1:0] KIND_NACK     = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;

    localparam int VEC_BITS  = 64;
    localparam int SLOT_BITS = 16;
    localparam int TAG_BITS  = 16;

    localparam logic CFG_MEMBER_COUNT = 1'b0;
    localparam logic CFG_SELF_INDEX   = 1'b1;

    typedef struct packed {
        logic [1:0]           kind;
        logic [1:0]           sender;
        logic [TAG_BITS-1:0]  tag;
        logic [SLOT_BITS-1:0] first;
        logic [SLOT_BITS-1:0] count;
    } t_result;

    typedef struct packed {
        logic [1:0]          sender;
        logic [VEC_BITS-1:0] vector;
        logic [TAG_BITS-1:0] tag;
    } t_held;

endpackage

// File: sv/causal_order_holdback_core.sv
`timescale 1ns / 1ps

// Receive side of causal-order multicast. Each input transfer is one message
// (sender, vector timestamp, payload tag). Messages from self or causally
// deliverable ones are delivered at once; others go to an ordered hold-back
// memory (a NACK follows when the sender stamp skipped ahead, an overflow
// result when the memory is full). One in-order pass over the hold-back then
// delivers every entry deliverable at its visit and compacts the rest. The
// output transfers of one message end with o_last set. A message passes
// through HEAD to decide, NACK when a NACK is sent, PREP to prime the memory
// read, PASS to visit each entry the hold-back holds (including a message just
// appended) and to close the pass, FIN to flush the final result, and back to
// IDLE; no new message is taken before IDLE. The pass visits one entry per
// cycle through the single read port of the hold-back memory while the output
// does not stall. Messages from senders outside the group give no output.
module causal_order_holdback_core import coh_pkg::*; #(
    parameter int MEMBERS    = 4,
    parameter int HOLD_DEPTH = 16,
    parameter int STAMP_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [2:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_source_index,
    input  logic [VEC_BITS-1:0]  i_received_vector,
    input  logic [TAG_BITS-1:0]  i_payload_tag,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_kind,
    output logic [1:0]           o_sender,
    output logic [TAG_BITS-1:0]  o_tag_out,
    output logic [SLOT_BITS-1:0] o_nack_first,
    output logic [SLOT_BITS-1:0] o_nack_count,
    output logic                 o_last
);

    localparam int AW = $clog2(HOLD_DEPTH);
    localparam int CW = $clog2(HOLD_DEPTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HEAD = 3'd1;
    localparam logic [2:0] ST_NACK = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_PASS = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]            r_state;
    logic [2:0]            r_member_count;
    logic [1:0]            r_self_index;
    logic [STAMP_BITS-1:0] r_clk [MEMBERS];
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         r_len;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_w;
    logic [1:0]            r_src;
    logic [VEC_BITS-1:0]   r_vec;
    logic [TAG_BITS-1:0]   r_tag;
    t_result               r_pend;
    logic                  r_pend_v;
    t_result               r_out;
    logic                  r_out_v;
    logic                  r_out_last;

    logic [2:0]  m;
    logic        can_emit;
    logic        can_gen;
    logic        gen;
    t_result     gen_res;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    t_held       mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_held       mem_rdata;

    // Effective group size: zero acts as one, above MEMBERS clamps.
    always_comb begin
        if (r_member_count == 3'd0) begin
            m = 3'd1;
        end else if (r_member_count > 3'(MEMBERS)) begin
            m = 3'(MEMBERS);
        end else begin
            m = r_member_count;
        end
    end

    function automatic logic [STAMP_BITS-1:0] slot_of(logic [VEC_BITS-1:0] v, int i);
        return v[SLOT_BITS*i +: STAMP_BITS];
    endfunction

    function automatic logic [STAMP_BITS-1:0] clk_of(logic [1:0] s);
        logic [STAMP_BITS-1:0] c;
        c = '0;
        for (int i = 0; i < MEMBERS; i++) begin
            if (s == 2'(i)) c = r_clk[i];
        end
        return c;
    endfunction

    // Sender entry one ahead, no other in-use entry ahead of the local clock.
    function automatic logic is_deliverable(logic [VEC_BITS-1:0] v, logic [1:0] s);
        logic ok;
        ok = (slot_of(v, int'(s)) == clk_of(s) + STAMP_BITS'(1));
        for (int i = 0; i < MEMBERS; i++) begin
            if (3'(i) < m && s != 2'(i) && slot_of(v, i) > r_clk[i]) ok = 1'b0;
        end
        return ok;
    endfunction

    logic [STAMP_BITS-1:0] head_nxt;
    logic [STAMP_BITS-1:0] head_got;
    logic                  head_dlv;
    logic                  pass_dlv;

    assign head_nxt = clk_of(r_src) + STAMP_BITS'(1);
    assign head_got = slot_of(r_vec, int'(r_src));
    assign head_dlv = is_deliverable(r_vec, r_src);
    assign pass_dlv = ({1'b0, mem_rdata.sender} < m)
                      && is_deliverable(mem_rdata.vector, mem_rdata.sender);

    assign can_emit = !r_out_v || !i_out_stall;
    assign can_gen  = !r_pend_v || can_emit;

    // Result generation: what each state would produce this cycle.
    always_comb begin
        gen     = 1'b0;
        gen_res = '0;
        unique case (r_state)
            ST_HEAD: begin
                gen            = (r_src == r_self_index) || head_dlv
                                 || (r_cnt == CW'(HOLD_DEPTH));
                gen_res.sender = r_src;
                gen_res.tag    = r_tag;
                gen_res.kind   = (r_src == r_self_index || head_dlv) ? KIND_DELIVER
                                                                     : KIND_OVERFLOW;
            end
            ST_NACK: begin
                gen            = 1'b1;
                gen_res.kind   = KIND_NACK;
                gen_res.sender = r_src;
                gen_res.first  = SLOT_BITS'(head_nxt);
                gen_res.count  = SLOT_BITS'(head_got - head_nxt);
            end
            ST_PASS: begin
                gen            = (r_idx != r_len) && pass_dlv;
                gen_res.kind   = KIND_DELIVER;
                gen_res.sender = mem_rdata.sender;
                gen_res.tag    = mem_rdata.tag;
            end
            default: begin
                gen = 1'b0;
            end
        endcase
    end

    // Step fires when its result, if any, can be taken into the pending slot.
    logic step;
    assign step = !gen || can_gen;

    // Output register loads from the pending slot: on a new result or the final flush.
    logic out_load;
    assign out_load = (gen && can_gen && r_pend_v)
                      || (r_state == ST_FIN && r_pend_v && can_emit);

    // Memory access: append in HEAD, compact in PASS.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cnt[AW-1:0];
        mem_wdata = '{sender: r_src, vector: r_vec, tag: r_tag};
        mem_raddr = '0;
        if (r_state == ST_HEAD && step && !(r_src == r_self_index) && !head_dlv
            && r_cnt != CW'(HOLD_DEPTH)) begin
            mem_we = 1'b1;
        end
        if (r_state == ST_PASS) begin
            mem_raddr = (r_idx != r_len && step) ? AW'(r_idx + CW'(1)) : r_idx[AW-1:0];
            if (r_idx != r_len && !pass_dlv) begin
                mem_we    = 1'b1;
                mem_waddr = r_w[AW-1:0];
                mem_wdata = mem_rdata;
            end
        end
    end

    coh_hold_mem #(.HOLD_DEPTH(HOLD_DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_member_count <= 3'd4;
            r_self_index   <= 2'd3;
            for (int i = 0; i < MEMBERS; i++) r_clk[i] <= '0;
            r_cnt          <= '0;
            r_pend_v       <= 1'b0;
            r_out_v        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MEMBER_COUNT) r_member_count <= i_cfg_data;
                else                               r_self_index   <= i_cfg_data[1:0];
            end

            // Load the output register, or drain it on a transfer.
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end

            // Push the pending result out; the new one becomes pending.
            if (gen && can_gen) begin
                if (r_pend_v) begin
                    r_out      <= r_pend;
                    r_out_last <= 1'b0;
                end
                r_pend   <= gen_res;
                r_pend_v <= 1'b1;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_src <= i_source_index;
                        r_vec <= i_received_vector;
                        r_tag <= i_payload_tag;
                        if ({1'b0, i_source_index} < m) r_state <= ST_HEAD;
                    end
                end
                ST_HEAD: begin
                    if (step) begin
                        if (r_src == r_self_index) begin
                            r_len   <= r_cnt;
                            r_state <= ST_PREP;
                        end else if (head_dlv) begin
                            for (int i = 0; i < MEMBERS; i++) begin
                                if (r_src == 2'(i)) r_clk[i] <= r_clk[i] + STAMP_BITS'(1);
                            end
                            r_len   <= r_cnt;
                            r_state <= ST_PREP;
                        end else begin
                            if (r_cnt != CW'(HOLD_DEPTH)) begin
                                r_cnt <= r_cnt + CW'(1);
                                r_len <= r_cnt + CW'(1);
                            end else begin
                                r_len <= r_cnt;
                            end
                            r_state <= (head_got > head_nxt) ? ST_NACK : ST_PREP;
                        end
                    end
                end
                ST_NACK: begin
                    if (step) r_state <= ST_PREP;
                end
                ST_PREP: begin
                    r_idx   <= '0;
                    r_w     <= '0;
                    r_state <= ST_PASS;
                end
                ST_PASS: begin
                    if (r_idx == r_len) begin
                        r_cnt   <= r_w;
                        r_state <= ST_FIN;
                    end else if (step) begin
                        r_idx <= r_idx + CW'(1);
                        if (pass_dlv) begin
                            for (int i = 0; i < MEMBERS; i++) begin
                                if (mem_rdata.sender == 2'(i))
                                    r_clk[i] <= r_clk[i] + STAMP_BITS'(1);
                            end
                        end else begin
                            r_w <= r_w + CW'(1);
                        end
                    end
                end
                ST_FIN: begin
                    // Flush the held-back final result with the last flag.
                    if (!r_pend_v) begin
                        r_state <= ST_IDLE;
                    end else if (can_emit) begin
                        r_out      <= r_pend;
                        r_out_last <= 1'b1;
                        r_pend_v   <= 1'b0;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_v;
    assign o_kind       = r_out.kind;
    assign o_sender     = r_out.sender;
    assign o_tag_out    = r_out.tag;
    assign o_nack_first = r_out.first;
    assign o_nack_count = r_out.count;
    assign o_last       = r_out_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(HOLD_DEPTH))
        else $error("hold-back count beyond depth");

    a_compact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS) |-> (r_w <= r_idx && r_idx <= r_len))
        else $error("compaction pointer ahead of scan");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_v)
        else $error("pending result left at idle");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == ST_FIN && r_state == ST_IDLE && $past(r_pend_v))
        |-> (r_out_v && r_out_last))
        else $error("final result not flagged last");

endmodule

// File: sv/coh_hold_mem.sv
`timescale 1ns / 1ps

module coh_hold_mem import coh_pkg::*; #(
    parameter int HOLD_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(HOLD_DEPTH)-1:0] i_waddr,
    input  t_held                         i_wdata,
    input  logic [$clog2(HOLD_DEPTH)-1:0] i_raddr,
    output t_held                         o_rdata
);

    t_held r_mem [HOLD_DEPTH];
    t_held r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
